// ===== hdl/bsil_pkg.sv =====
package bsil_pkg;

  localparam int KeyWidth = 38;
  localparam int KeyLowBits = 30;
  localparam int SubkeyWidth = 8;
  localparam int NibbleShift = 4;
  localparam int OffsetWidth = 17;

  typedef enum logic [1:0] {
    OP_WRITE_END = 2'd0,
    OP_WRITE_SUBKEY = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_EXACT = 2'd0,
    KIND_SMALL = 2'd1,
    KIND_NIBBLE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [15:0] table_address;
    logic [16:0] table_value;
    logic [37:0] key;
  } in_item_t;

  typedef struct packed {
    logic [16:0] range_begin;
    logic [16:0] range_end;
    logic [1:0] match_kind;
    logic key_error;
  } out_item_t;

  typedef struct packed {
    op_t op;
    logic bad_key;
    logic [15:0] address;
    logic [16:0] value;
    logic [29:0] bucket;
    logic [7:0] subkey;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_END_RD,
    ST_END_WAIT,
    ST_BEGIN_WAIT,
    ST_SPAN,
    ST_SEARCH_RD,
    ST_SEARCH_WAIT,
    ST_DECIDE,
    ST_UP_RD,
    ST_UP_WAIT,
    ST_DOWN_RD,
    ST_DOWN_WAIT,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/bsil_front.sv =====
module bsil_front
  import bsil_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_take,
  output cmd_t     q_data
);

  localparam int Depth = 2;

  cmd_t       fifo [Depth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd;
  logic       push;
  logic       pop;

  always_comb begin
    cmd.op = op_t'(in_data.operation);
    cmd.address = in_data.table_address;
    cmd.value = in_data.table_value;
    cmd.bucket = in_data.key[KeyLowBits-1:0];
    cmd.subkey = in_data.key[KeyWidth-1:KeyLowBits];
    cmd.bad_key = 1'b0;
  end

  assign in_stall = (count == 2'(Depth));
  assign push = in_valid && !in_stall;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_take;
  assign q_data = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/bsil_back.sv =====
module bsil_back
  import bsil_pkg::*;
#(
  parameter int BUCKET_BITS = 16,
  parameter int NODE_INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [16:0] limit,
  input  logic        q_valid,
  output logic        q_take,
  input  cmd_t        q_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int NW = NODE_INDEX_BITS + 1;
  localparam logic [NW-1:0] NodeDepth = NW'(1) << NODE_INDEX_BITS;

  logic [16:0] end_mem [2**BUCKET_BITS];
  logic [7:0]  sub_mem [2**NODE_INDEX_BITS];

  state_t state;
  state_t state_next;

  cmd_t    cur;
  logic [BUCKET_BITS-1:0] end_addr;
  logic [16:0] end_rd;
  logic [NODE_INDEX_BITS-1:0] sub_addr;
  logic [7:0] sub_rd;
  logic [NW-1:0] span_end;
  logic [NW-1:0] span_begin;
  logic [NW-1:0] first;
  logic [NW-1:0] len;
  logic [NW-1:0] lo;
  logic [NW-1:0] hi;
  logic          pass_upper;
  logic [1:0]    kind;
  logic          err;
  logic [NW-1:0] mid;
  logic [NW-1:0] half;
  logic          go_right;
  logic [NW-1:0] sat_rd;
  logic          wr_end;
  logic          wr_sub;
  logic [7:0]    sub_key;
  logic          out_free;

  assign sub_key = cur.subkey;
  assign half = len >> 1;
  assign mid = first + half;
  assign go_right = pass_upper ? (sub_rd <= sub_key) : (sub_rd < sub_key);
  assign sat_rd = (17'(end_rd) > 17'(NodeDepth)) ? NodeDepth : NW'(end_rd);
  assign out_free = !out_valid || !out_stall;

  assign wr_end = (state == ST_IDLE) && q_valid && (q_data.op == OP_WRITE_END)
                  && (32'(q_data.address) < (32'd1 << BUCKET_BITS));
  assign wr_sub = (state == ST_IDLE) && q_valid && (q_data.op == OP_WRITE_SUBKEY)
                  && (33'(q_data.address) < (33'd1 << NODE_INDEX_BITS));

  always_ff @(posedge clk) begin
    if (wr_end) begin
      end_mem[q_data.address[BUCKET_BITS-1:0]] <= q_data.value;
    end
    end_rd <= end_mem[end_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_sub) begin
      sub_mem[q_data.address[NODE_INDEX_BITS-1:0]] <= q_data.value[7:0];
    end
    sub_rd <= sub_mem[sub_addr];
  end

  always_comb begin
    end_addr = cur.bucket[BUCKET_BITS-1:0];
    if (state == ST_END_WAIT) begin
      end_addr = cur.bucket[BUCKET_BITS-1:0] - 1'b1;
    end
    sub_addr = mid[NODE_INDEX_BITS-1:0];
    if (state == ST_UP_RD) begin
      sub_addr = hi[NODE_INDEX_BITS-1:0];
    end else if (state == ST_DOWN_RD) begin
      sub_addr = lo[NODE_INDEX_BITS-1:0] - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && q_data.op == OP_QUERY) begin
          state_next = ST_END_RD;
        end
      end
      ST_END_RD: begin
        if (cur.bucket[KeyLowBits-1:BUCKET_BITS] != '0) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_END_WAIT;
        end
      end
      ST_END_WAIT:   state_next = ST_BEGIN_WAIT;
      ST_BEGIN_WAIT: state_next = ST_SPAN;
      ST_SPAN:       state_next = ST_SEARCH_RD;
      ST_SEARCH_RD: begin
        if (len == '0) begin
          state_next = pass_upper ? ST_DECIDE : ST_SEARCH_RD;
        end else begin
          state_next = ST_SEARCH_WAIT;
        end
      end
      ST_SEARCH_WAIT: state_next = ST_SEARCH_RD;
      ST_DECIDE: begin
        if (lo < hi || 17'(span_end - span_begin) <= limit) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_UP_RD;
        end
      end
      ST_UP_RD: begin
        state_next = (hi < span_end) ? ST_UP_WAIT : ST_DOWN_RD;
      end
      ST_UP_WAIT: begin
        state_next = (sub_rd[7:4] == sub_key[7:4]) ? ST_UP_RD : ST_DOWN_RD;
      end
      ST_DOWN_RD: begin
        state_next = (lo > span_begin) ? ST_DOWN_WAIT : ST_EMIT;
      end
      ST_DOWN_WAIT: begin
        state_next = (sub_rd[7:4] == sub_key[7:4]) ? ST_DOWN_RD : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_take = (state == ST_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur <= q_data;
        err <= 1'b0;
        kind <= KIND_EXACT;
      end
      ST_END_RD: begin
        if (cur.bucket[KeyLowBits-1:BUCKET_BITS] != '0) begin
          err <= 1'b1;
          lo <= '0;
          hi <= '0;
        end
      end
      ST_END_WAIT: span_end <= sat_rd;
      ST_BEGIN_WAIT: begin
        span_begin <= (cur.bucket[BUCKET_BITS-1:0] == '0) ? '0 : sat_rd;
      end
      ST_SPAN: begin
        if (span_begin > span_end) begin
          span_begin <= span_end;
          first <= span_end;
          len <= '0;
        end else begin
          first <= span_begin;
          len <= span_end - span_begin;
        end
        pass_upper <= 1'b0;
      end
      ST_SEARCH_RD: begin
        if (len == '0) begin
          if (pass_upper) begin
            hi <= first;
          end else begin
            lo <= first;
            first <= span_begin;
            len <= span_end - span_begin;
            pass_upper <= 1'b1;
          end
        end
      end
      ST_SEARCH_WAIT: begin
        if (go_right) begin
          first <= mid + 1'b1;
          len <= len - half - 1'b1;
        end else begin
          len <= half;
        end
      end
      ST_DECIDE: begin
        if (lo < hi) begin
          kind <= KIND_EXACT;
        end else if (17'(span_end - span_begin) <= limit) begin
          lo <= span_begin;
          hi <= span_end;
          kind <= KIND_SMALL;
        end else begin
          hi <= lo;
          kind <= KIND_NIBBLE;
        end
      end
      ST_UP_WAIT: begin
        if (sub_rd[7:4] == sub_key[7:4]) begin
          hi <= hi + 1'b1;
        end
      end
      ST_DOWN_WAIT: begin
        if (sub_rd[7:4] == sub_key[7:4]) begin
          lo <= lo - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_data.range_begin <= 17'(lo);
      out_data.range_end <= 17'(hi);
      out_data.match_kind <= kind;
      out_data.key_error <= err;
    end
  end

endmodule

// ===== hdl/bucketed_subkey_index_lookup_top.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_data (in_item_t)
// out     | output    | out_valid/out_stall| out_data (out_item_t)
// cfg     | input     | cfg_we             | cfg_data (small_bucket_limit)
// A query runs two halving passes over its bucket's span, p probes per pass (up to log2(span)+1);
// the read loop on the single-port subkey store sets how long it takes.
// The nibble walk reads one node at a time on each side, stopping at a nibble mismatch or the span edge.
// Requests pass through the two-entry queue; a table write is taken from it while the engine is idle.
// rst is synchronous; tables hold garbage until loaded, the limit resets to 8.
// A stalled result holds the engine in its emit step.
module bucketed_subkey_index_lookup_top
  import bsil_pkg::*;
#(
  parameter int BUCKET_BITS = 16,
  parameter int NODE_INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data
);

  logic [16:0] limit;
  logic        q_valid;
  logic        q_take;
  cmd_t        q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 17'd8;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  bsil_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
  );

  bsil_back #(
    .BUCKET_BITS(BUCKET_BITS), .NODE_INDEX_BITS(NODE_INDEX_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .limit(limit), .q_valid(q_valid), .q_take(q_take),
    .q_data(q_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
